FILE: src/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants for the insertion sort block
// Holds the counter widths, their saturation limits, the stream field
// layout, and the control struct that drives the operation counters.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned MOVES_W   = 12;
  localparam int unsigned CMPS_W    = 11;
  localparam int unsigned OUT_DW    = 56;

  localparam logic [MOVES_W-1:0] MOVES_MAX = {MOVES_W{1'b1}};
  localparam logic [CMPS_W-1:0]  CMPS_MAX  = {CMPS_W{1'b1}};

  // Counter update requests from the sequencer
  typedef struct packed {
    logic clr;       // clear all counters and the drop flag
    logic add_two;   // insertion into a non-empty store
    logic add_move;  // one element shifted up
    logic add_cmp;   // one key comparison
    logic set_drop;  // value dropped because the store is full
  } cnt_ctl_t;

endpackage

FILE: src/isc_store.sv
// ----------------------------------------------------------------------------
// isc_store: sorted element store
// Single-port-write, single-port-read synchronous memory with a registered
// read port. Contents are not initialized.
// ----------------------------------------------------------------------------
module isc_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [isc_pkg::VALUE_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [isc_pkg::VALUE_W-1:0]   rd_data
);

  logic [isc_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [isc_pkg::VALUE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/isc_counts.sv
// ----------------------------------------------------------------------------
// isc_counts: operation counters
// Saturating move and comparison totals plus the sticky overflow flag for
// the set currently being collected.
// ----------------------------------------------------------------------------
module isc_counts (
  input  logic                          clk,
  input  logic                          rst_n,
  input  isc_pkg::cnt_ctl_t             ctl,
  output logic [isc_pkg::MOVES_W-1:0]   moves,
  output logic [isc_pkg::CMPS_W-1:0]    compares,
  output logic                          dropped
);

  logic [isc_pkg::MOVES_W-1:0] moves_r, moves_nxt;
  logic [isc_pkg::CMPS_W-1:0]  cmps_r, cmps_nxt;
  logic                        drop_r, drop_nxt;
  logic [isc_pkg::MOVES_W:0]   moves_sum;
  logic [isc_pkg::MOVES_W:0]   moves_inc;

  // Work out the next totals, saturating at the field limits
  always_comb begin
    moves_inc = '0;
    if (ctl.add_two) begin
      moves_inc = (isc_pkg::MOVES_W+1)'(2);
    end else if (ctl.add_move) begin
      moves_inc = (isc_pkg::MOVES_W+1)'(1);
    end
    moves_sum = {1'b0, moves_r} + moves_inc;
    moves_nxt = moves_sum[isc_pkg::MOVES_W] ? isc_pkg::MOVES_MAX
                                            : moves_sum[isc_pkg::MOVES_W-1:0];
    cmps_nxt  = cmps_r;
    if (ctl.add_cmp && (cmps_r != isc_pkg::CMPS_MAX)) begin
      cmps_nxt = cmps_r + isc_pkg::CMPS_W'(1);
    end
    drop_nxt = drop_r | ctl.set_drop;
    if (ctl.clr) begin
      moves_nxt = '0;
      cmps_nxt  = '0;
      drop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moves_r <= '0;
      cmps_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      moves_r <= moves_nxt;
      cmps_r  <= cmps_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign moves    = moves_r;
  assign compares = cmps_r;
  assign dropped  = drop_r;

endmodule

FILE: src/insertion_sort_with_op_counts.sv
// Insertion: an accepted value is written straight into an empty store or dropped from a full one;
//   else a walk from the top does one store read/compare/write per shifted element, then fills the gap.
// Emission: on a last beat, read, load and handshake steps per sorted element, plus stalls.
// One input beat is worked at a time; in_tready is high only in the idle state.
// Reset (rst_n, synchronous) clears control, counts and flags; the store is not
//   initialized since only entries below the element count are ever read.
// ----------------------------------------------------------------------------
// insertion_sort_with_op_counts: streaming insertion sort with op counters
// Inserts each value into a memory-held sorted list by walking down from
// the top, counts moves and comparisons, and streams the list out on last.
// ----------------------------------------------------------------------------
module insertion_sort_with_op_counts #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] value
  input  logic                          in_tlast,   // last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [isc_pkg::OUT_DW-1:0]    out_tdata,  // [31:0] sorted_value,
                                                    // [43:32] move_count,
                                                    // [54:44] compare_count,
                                                    // [55] zero pad
  output logic                          out_tlast,  // end_of_run
  output logic                          out_tuser   // overflow
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LEN);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_PLACE = 6'b000100,
    S_ERD   = 6'b001000,
    S_ELD   = 6'b010000,
    S_EHOLD = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic [AW-1:0]                 k_r, k_nxt;
  logic [isc_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic                          last_r, last_nxt;
  logic                          ovalid_r, ovalid_nxt;
  logic [isc_pkg::VALUE_W-1:0]   odata_r;
  logic                          olast_r;
  logic                          load_out;

  logic                          wr_en, rd_en;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic [isc_pkg::VALUE_W-1:0]   wr_data, rd_data;
  isc_pkg::cnt_ctl_t             cnt_ctl;
  logic [isc_pkg::MOVES_W-1:0]   moves;
  logic [isc_pkg::CMPS_W-1:0]    compares;
  logic                          dropped;

  logic                          in_acc;
  logic                          shift_up;
  logic                          emit_last;

  assign in_acc    = in_tvalid && in_tready;
  assign shift_up  = $signed(rd_data) > $signed(val_r);
  assign emit_last = ((CW'(k_r) + CW'(1)) == count_r);

  // Sequencer: insertion walk and output sweep
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    val_nxt    = val_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = val_r;
    rd_en      = 1'b0;
    rd_addr    = pos_r - AW'(1);
    cnt_ctl    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt  = in_tdata;
          last_nxt = in_tlast;
          k_nxt    = '0;
          if (count_r == FULL_CNT) begin
            // Drop the beat; a last still closes the set
            cnt_ctl.set_drop = 1'b1;
            if (in_tlast) begin
              state_nxt = S_ERD;
            end
          end else if (count_r == '0) begin
            // First element goes straight to the bottom entry
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_tdata;
            count_nxt = CW'(1);
            if (in_tlast) begin
              state_nxt = S_ERD;
            end
          end else begin
            // Start the walk at the top entry
            cnt_ctl.add_two = 1'b1;
            pos_nxt   = count_r[AW-1:0];
            rd_en     = 1'b1;
            rd_addr   = count_r[AW-1:0] - AW'(1);
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        cnt_ctl.add_cmp = 1'b1;
        wr_en = 1'b1;
        if (shift_up) begin
          // Shift the larger entry up one place
          cnt_ctl.add_move = 1'b1;
          wr_data = rd_data;
          pos_nxt = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_r - AW'(1) - AW'(1);
          end
        end else begin
          // Stop here and drop the new value into the gap
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? S_ERD : S_IDLE;
        end
      end
      S_PLACE: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? S_ERD : S_IDLE;
      end
      S_ERD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        load_out   = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_EHOLD;
      end
      S_EHOLD: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (emit_last) begin
            // Run done: clear for the next set
            cnt_ctl.clr = 1'b1;
            count_nxt   = '0;
            state_nxt   = S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    if (load_out) begin
      odata_r <= rd_data;
      olast_r <= emit_last;
    end
  end

  isc_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  isc_counts u_counts (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cnt_ctl),
    .moves    (moves),
    .compares (compares),
    .dropped  (dropped)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, compares, moves, odata_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = dropped;

endmodule

FILE: tb/sv/tb_insertion_sort_with_op_counts.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_insertion_sort_with_op_counts: self-checking bench for the sort block
// Streams sets of signed values into the block with random gaps and stalls on
// both sides. A behavioral insertion sort predicts each sorted beat, with its
// move and compare totals and the drop flag. Every output beat is checked in
// order against the oldest prediction. A directed table comes first, then
// random sets that include a full store and a set that overflows it.
// ----------------------------------------------------------------------------
module tb_insertion_sort_with_op_counts;

  localparam int unsigned MAX_LEN     = 64;
  localparam int          RND_ITEMS   = 176;
  localparam int          HOLD_CYCLES = 400;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          DRAIN_CYC   = 20;
  localparam int          NUM_DIR     = 24;

  // One output beat: sorted value, end of run, totals and overflow
  typedef struct packed {
    logic [31:0]                 value;
    logic                        eor;
    logic [isc_pkg::MOVES_W-1:0] moves;
    logic [isc_pkg::CMPS_W-1:0]  cmps;
    logic                        ovf;
  } sorted_beat_t;

  // One directed row; want holds a typed beat only where typed is set
  typedef struct packed {
    logic [31:0]  value;
    logic         last;
    logic         typed;
    sorted_beat_t want;
  } stim_row_t;

  localparam sorted_beat_t NO_WANT = '0;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [31:0]                in_tdata;   // [31:0] value
  logic                       in_tlast;   // last
  logic                       out_tvalid;
  logic                       out_tready;
  logic [isc_pkg::OUT_DW-1:0] out_tdata;  // [31:0] sorted_value, [43:32] move_count,
                                          // [54:44] compare_count, [55] zero pad
  logic                       out_tlast;  // end_of_run
  logic                       out_tuser;  // overflow

  insertion_sort_with_op_counts #(
    .MAX_LEN (MAX_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed rows: single-value sets at the extremes and around zero carry typed beats
  stim_row_t dir_rows [NUM_DIR] = '{
    '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 12'd0, 11'd0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1, 12'd0, 11'd0, 1'b0}},
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 12'd0, 11'd0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 12'd0, 11'd0, 1'b0}},
    '{32'h0000_0005, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFD, 1'b1, 1'b0, NO_WANT},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, NO_WANT},
    '{32'h8000_0000, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0007, 1'b1, 1'b0, NO_WANT},
    '{32'h0000_0004, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0004, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0004, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0004, 1'b1, 1'b0, NO_WANT},
    '{32'h0000_0003, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0002, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0001, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0000, 1'b1, 1'b0, NO_WANT},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
    '{32'h7FFF_FFFE, 1'b1, 1'b0, NO_WANT},
    '{32'h8000_0001, 1'b0, 1'b0, NO_WANT},
    '{32'h5555_5555, 1'b0, 1'b0, NO_WANT},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, NO_WANT},
    '{32'h8000_0001, 1'b1, 1'b0, NO_WANT}
  };

  // Shadow state of the sorter
  logic signed [31:0] shadow_store [MAX_LEN];
  int                 shadow_count;
  int                 shadow_moves;
  int                 shadow_cmps;
  logic               shadow_drop;

  sorted_beat_t pending_sorted [$];

  int  items_sent;
  int  sets_sent;
  int  drop_sets;
  int  beats_checked;
  int  mism_cnt;
  int  stray_cnt;
  int  idle_cycles;
  bit  tx_quiet;
  bit  held_off;

  // Insert one accepted value; on last, queue the sorted run and clear
  function automatic void insert_and_emit(logic [31:0] v, logic l, logic keep);
    int           pos;
    int           shifts;
    sorted_beat_t b;
    if (shadow_count < MAX_LEN) begin
      pos    = shadow_count;
      shifts = 0;
      while (pos > 0 && shadow_store[pos-1] > $signed(v)) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
        shifts++;
      end
      shadow_store[pos] = $signed(v);
      if (shadow_count > 0)
        shadow_moves = shadow_moves + 2 + shifts;
      shadow_cmps = shadow_cmps + shifts + ((pos > 0) ? 1 : 0);
      if (shadow_moves > int'(isc_pkg::MOVES_MAX))
        shadow_moves = int'(isc_pkg::MOVES_MAX);
      if (shadow_cmps > int'(isc_pkg::CMPS_MAX))
        shadow_cmps = int'(isc_pkg::CMPS_MAX);
      shadow_count++;
    end else begin
      shadow_drop = 1'b1;
    end
    if (l) begin
      if (shadow_drop)
        drop_sets++;
      for (int k = 0; k < shadow_count; k++) begin
        b.value = shadow_store[k];
        b.eor   = (k == shadow_count - 1);
        b.moves = shadow_moves[isc_pkg::MOVES_W-1:0];
        b.cmps  = shadow_cmps[isc_pkg::CMPS_W-1:0];
        b.ovf   = shadow_drop;
        if (keep)
          pending_sorted.push_back(b);
      end
      sets_sent++;
      shadow_count = 0;
      shadow_moves = 0;
      shadow_cmps  = 0;
      shadow_drop  = 1'b0;
    end
  endfunction

  // Offer one beat after a random gap; called and returns at a falling edge
  task automatic drive_beat(logic [31:0] v, logic l, logic keep);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    insert_and_emit(v, l, keep);
    items_sent++;
    @(negedge clk);
  endtask

  // Mix extremes, a narrow range for ties, and full-width values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    int set_idx;
    int rnd_items;
    int len;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    shadow_count = 0;
    shadow_moves = 0;
    shadow_cmps  = 0;
    shadow_drop  = 1'b0;
    items_sent   = 0;
    sets_sent    = 0;
    drop_sets    = 0;
    tx_quiet     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      drive_beat(dir_rows[i].value, dir_rows[i].last, !dir_rows[i].typed);
      if (dir_rows[i].typed)
        pending_sorted.push_back(dir_rows[i].want);
    end

    // Random sets; one fills the store exactly, one overflows it with last dropped
    set_idx   = 0;
    rnd_items = 0;
    while (rnd_items < RND_ITEMS || set_idx < 6) begin
      case (set_idx)
        2:       len = MAX_LEN + 1;
        5:       len = MAX_LEN;
        default: len = $urandom_range(1, 8);
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++)
        drive_beat(pick_value(), k == len - 1, 1'b1);
      rnd_items += len;
      set_idx++;
    end
    in_tvalid <= 1'b0;

    // Drain
    while (pending_sorted.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d values in %0d sets (%0d with dropped values), checked %0d sorted beats.",
             items_sent, sets_sent, drop_sets, beats_checked);
    $display("Mismatches: %0d, unexpected beats: %0d, beats still owed: %0d.",
             mism_cnt, stray_cnt, pending_sorted.size());
    if (mism_cnt == 0 && stray_cnt == 0 && pending_sorted.size() == 0) begin
      $display("insertion_sort_with_op_counts regression: pass");
    end else begin
      $display("insertion_sort_with_op_counts regression: fail");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off mid-run, compare each beat
  initial begin
    int           gap;
    int           quiet_left;
    sorted_beat_t got;
    sorted_beat_t want;
    out_tready    = 1'b0;
    beats_checked = 0;
    mism_cnt      = 0;
    stray_cnt     = 0;
    held_off      = 1'b0;
    quiet_left    = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (quiet_left == 0 && $urandom_range(0, 15) == 0)
        quiet_left = 24;
      if (quiet_left > 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        gap = $urandom_range(0, 7);
      end
      if (!held_off && beats_checked >= 40 && pending_sorted.size() > 0) begin
        held_off = 1'b1;
        gap      = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.value = out_tdata[31:0];
      got.moves = out_tdata[43:32];
      got.cmps  = out_tdata[54:44];
      got.eor   = out_tlast;
      got.ovf   = out_tuser;
      if (pending_sorted.size() == 0) begin
        stray_cnt++;
        if (stray_cnt + mism_cnt <= 10)
          $display("Unexpected beat at %0t: value %0d eor %0b moves %0d cmps %0d ovf %0b",
                   $realtime, $signed(got.value), got.eor, got.moves, got.cmps, got.ovf);
      end else begin
        want = pending_sorted.pop_front();
        if (got !== want) begin
          mism_cnt++;
          if (stray_cnt + mism_cnt <= 10)
            $display({"Mismatch at %0t on beat %0d: expected value %0d eor %0b moves %0d ",
                      "cmps %0d ovf %0b, got value %0d eor %0b moves %0d cmps %0d ovf %0b"},
                     $realtime, beats_checked, $signed(want.value), want.eor, want.moves,
                     want.cmps, want.ovf, $signed(got.value), got.eor, got.moves,
                     got.cmps, got.ovf);
        end
      end
      beats_checked++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("insertion_sort_with_op_counts regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: sim.f
src/isc_pkg.sv
src/isc_store.sv
src/isc_counts.sv
src/insertion_sort_with_op_counts.sv
tb/sv/tb_insertion_sort_with_op_counts.sv
